>>> src/xcfp_pkg.sv
// shared types and constants for the xor checked frame parser
package xcfp_pkg;

   localparam logic [7:0]  SYNC_FIRST        = 8'hA0;
   localparam logic [7:0]  SYNC_SECOND       = 8'hA1;
   localparam logic [7:0]  BYTE_CR           = 8'h0D;
   localparam logic [7:0]  BYTE_LF           = 8'h0A;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1000;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [0:0]  REG_MAX_PAYLOAD = 1'b0;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_LENHI = 3'd2,
      PH_LENLO = 3'd3,
      PH_DATA  = 3'd4,
      PH_CHECK = 3'd5,
      PH_CR    = 3'd6,
      PH_LF    = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_CHECKSUM = 2'd1,
      ST_FRAMING  = 2'd2
   } status_type;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [7:0]  payload_byte;
      logic [1:0]  frame_status;
      logic [15:0] frame_length;
   } result_type;

endpackage

>>> src/xcfp_core.sv
// frame parsing state machine, one byte per step
module xcfp_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rx_byte,
   input  logic [15:0]        max_payload,
   output xcfp_pkg::result_type result
);
   import xcfp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  xor_ff, xor_in;
   logic        cbad_ff, cbad_in;
   logic        fbad_ff, fbad_in;
   logic [15:0] len_raw;
   logic [15:0] len_cap;

   assign len_raw = length_ff | {8'h00, rx_byte};
   assign len_cap = (len_raw > max_payload) ? max_payload : len_raw;

   // next state
   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      left_in   = left_ff;
      xor_in    = xor_ff;
      cbad_in   = cbad_ff;
      fbad_in   = fbad_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == SYNC_FIRST) begin
               length_in = '0;
               left_in   = '0;
               xor_in    = '0;
               cbad_in   = 1'b0;
               fbad_in   = 1'b0;
               phase_in  = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (rx_byte != SYNC_SECOND) fbad_in = 1'b1;
            phase_in = PH_LENHI;
         end
         PH_LENHI: begin
            length_in = {rx_byte, 8'h00};
            phase_in  = PH_LENLO;
         end
         PH_LENLO: begin
            length_in = len_cap;
            left_in   = len_cap;
            phase_in  = (len_cap == 16'd0) ? PH_CHECK : PH_DATA;
         end
         PH_DATA: begin
            xor_in  = xor_ff ^ rx_byte;
            left_in = left_ff - 16'd1;
            if (left_ff == 16'd1) phase_in = PH_CHECK;
         end
         PH_CHECK: begin
            if (rx_byte != xor_ff) cbad_in = 1'b1;
            phase_in = PH_CR;
         end
         PH_CR: begin
            if (rx_byte != BYTE_CR) fbad_in = 1'b1;
            phase_in = PH_LF;
         end
         PH_LF: begin
            if (rx_byte != BYTE_LF) fbad_in = 1'b1;
            phase_in = PH_HUNT;
         end
         default: phase_in = PH_HUNT;
      endcase
   end

   // result for the byte in hand
   always_comb begin
      result = '0;
      unique case (phase_ff)
         PH_DATA: begin
            result.valid        = 1'b1;
            result.kind         = KIND_PAYLOAD;
            result.payload_byte = rx_byte;
         end
         PH_LF: begin
            result.valid        = 1'b1;
            result.kind         = KIND_END;
            result.frame_length = length_ff;
            priority if (cbad_ff) begin
               result.frame_status = ST_CHECKSUM;
            end else if (fbad_ff || (rx_byte != BYTE_LF)) begin
               result.frame_status = ST_FRAMING;
            end else begin
               result.frame_status = ST_OK;
            end
         end
         default: result = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         length_ff <= '0;
         left_ff   <= '0;
         xor_ff    <= '0;
         cbad_ff   <= 1'b0;
         fbad_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         left_ff   <= left_in;
         xor_ff    <= xor_in;
         cbad_ff   <= cbad_in;
         fbad_ff   <= fbad_in;
      end
   end

endmodule

>>> src/xor_checked_frame_parser.sv
// top level of the xor checked frame parser: handshakes, registers and parser core
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_rx_byte
//  rsp     | out       | rsp_valid/rsp_stall | rsp_kind, rsp_payload_byte,
//          |           |                     | rsp_frame_status, rsp_frame_length
//  csr     | in/out    | apb, pready high    | max_payload at byte address 0
//
// one item a cycle sustained while the result side does not stall; an accepted
// item passes through the input register, the single parser step and the result
// register in turn
// reset clears all control state and loads max_payload with 1000
// a stalled result holds the parser step; the input register still takes an
// item while it is empty, so one item sits ready behind the waiting result
module xor_checked_frame_parser (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_rx_byte,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_kind,
   output logic [7:0]                         rsp_payload_byte,
   output logic [1:0]                         rsp_frame_status,
   output logic [15:0]                        rsp_frame_length,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [xcfp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [xcfp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [xcfp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import xcfp_pkg::*;

   // configuration register
   logic [15:0] max_payload_ff;
   logic [0:0]  csr_index;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-1];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_write && (csr_index == REG_MAX_PAYLOAD)) begin
         max_payload_ff <= csr_pwdata[15:0];
      end
   end

   // read back, unknown index reads zero
   always_comb begin
      csr_prdata = '0;
      if (csr_index == REG_MAX_PAYLOAD) begin
         csr_prdata = {{(CSR_DATA_W-16){1'b0}}, max_payload_ff};
      end
   end

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       req_take;
   logic       advance;

   // the held byte steps the parser once the result register can take its result
   assign advance   = in_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // parser step
   result_type step_result;

   xcfp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (in_byte_ff),
      .max_payload (max_payload_ff),
      .result      (step_result)
   );

   // result register
   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff;
   logic [7:0]  out_byte_ff;
   logic [1:0]  out_status_ff;
   logic [15:0] out_length_ff;
   logic        out_load;

   assign out_load = advance && step_result.valid;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff   <= step_result.kind;
         out_byte_ff   <= step_result.payload_byte;
         out_status_ff <= step_result.frame_status;
         out_length_ff <= step_result.frame_length;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_frame_status = out_status_ff;
   assign rsp_frame_length = out_length_ff;

endmodule

>>> verif/xor_checked_frame_parser_tb.sv
// self-checking testbench for the xor checked frame parser
module xor_checked_frame_parser_tb;
   import xcfp_pkg::*;

   // register map: max_payload at byte address 0, next word unused
   localparam logic [CSR_ADDR_W-1:0] MAX_PAYLOAD_ADDR = CSR_ADDR_W'(4 * int'(REG_MAX_PAYLOAD));
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR = CSR_ADDR_W'(4 * (int'(REG_MAX_PAYLOAD) + 1));

   localparam int SETTLE_CYCLES   = 6;     // covers the input and result registers with margin
   localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off to fill the block
   localparam int QUIET_LIMIT     = 3000;  // cycles without any handshake before giving up
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 95;

   // one expected result item
   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      status_type  frame_status;
      logic [15:0] frame_length;
   } frame_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_rx_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_kind;
   logic [7:0]            rsp_payload_byte;
   logic [1:0]            rsp_frame_status;
   logic [15:0]           rsp_frame_length;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   xor_checked_frame_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_status (rsp_frame_status),
      .rsp_frame_length (rsp_frame_length),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #6 clock = ~clock;

   // parser state as the testbench sees it
   phase_type     parse_phase  = PH_HUNT;
   logic [15:0]   length_seen  = '0;
   logic [15:0]   bytes_to_go  = '0;
   logic [7:0]    xor_acc      = '0;
   logic          sum_fault    = 1'b0;
   logic          frame_fault  = 1'b0;
   logic [15:0]   cap_value    = MAX_PAYLOAD_RESET;

   frame_result_type expected_results [$];
   int unsigned   parsed_items = 0;   // items not thrown away by the hunt
   int unsigned   error_count  = 0;
   int unsigned   quiet_cycles = 0;

   // idling controls for the sender and the receiver process
   bit tx_idle_on       = 1'b1;
   bit rx_idle_on       = 1'b1;
   bit hold_off_request = 1'b0;

   function automatic void report_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch %0d: %s", error_count, msg);
   endfunction

   // advance the parser by one received byte and queue what it gives
   function automatic void predict_rx_byte(input logic [7:0] b);
      frame_result_type r;
      logic [15:0]   len;
      if (parse_phase != PH_HUNT || b == SYNC_FIRST) parsed_items++;
      case (parse_phase)
         PH_HUNT: begin
            if (b == SYNC_FIRST) begin
               length_seen = '0;
               bytes_to_go = '0;
               xor_acc     = '0;
               sum_fault   = 1'b0;
               frame_fault = 1'b0;
               parse_phase = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            // a wrong second sync is taken in place, not a resync
            if (b != SYNC_SECOND) frame_fault = 1'b1;
            parse_phase = PH_LENHI;
         end
         PH_LENHI: begin
            length_seen = {b, 8'h00};
            parse_phase = PH_LENLO;
         end
         PH_LENLO: begin
            len = length_seen | {8'h00, b};
            if (len > cap_value) len = cap_value;
            length_seen = len;
            bytes_to_go = len;
            parse_phase = (len == 16'd0) ? PH_CHECK : PH_DATA;
         end
         PH_DATA: begin
            xor_acc     = xor_acc ^ b;
            bytes_to_go = bytes_to_go - 16'd1;
            if (bytes_to_go == 16'd0) parse_phase = PH_CHECK;
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            r.frame_status = ST_OK;
            r.frame_length = '0;
            expected_results.push_back(r);
         end
         PH_CHECK: begin
            if (b != xor_acc) sum_fault = 1'b1;
            parse_phase = PH_CR;
         end
         PH_CR: begin
            if (b != BYTE_CR) frame_fault = 1'b1;
            parse_phase = PH_LF;
         end
         default: begin
            if (b != BYTE_LF) frame_fault = 1'b1;
            parse_phase    = PH_HUNT;
            r.kind         = KIND_END;
            r.payload_byte = '0;
            // checksum mismatch wins over framing error
            r.frame_status = sum_fault ? ST_CHECKSUM : (frame_fault ? ST_FRAMING : ST_OK);
            r.frame_length = length_seen;
            expected_results.push_back(r);
         end
      endcase
   endfunction

   // offer one item after a random gap and hold it until taken
   task automatic send_rx_byte(input logic [7:0] b);
      int unsigned gap;
      gap = tx_idle_on ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_rx_byte(b);
   endtask

   // drop valid, let every queued result drain, then let the pipeline settle
   task automatic wait_block_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_max_payload_read();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= MAX_PAYLOAD_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[15:0] !== cap_value)
         report_error($sformatf("max_payload read expected %0d got %0d",
                                cap_value, csr_prdata[15:0]));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // upper data bits are junk, only the low 16 bits belong to the register
   task automatic set_max_payload(input logic [15:0] value);
      wait_block_idle();
      write_csr(MAX_PAYLOAD_ADDR, {16'($urandom), value});
      cap_value = value;
      check_max_payload_read();
   endtask

   task automatic test_reset_register();
      check_max_payload_read();
   endtask

   // hunting over garbage, an empty good frame, and a frame with a wrong second sync, checksum and CR
   task automatic test_directed_frames();
      logic [7:0] stream [0:16] = '{
         8'h00, 8'hFF,
         SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h00, 8'h00, BYTE_CR, BYTE_LF,
         SYNC_FIRST, 8'h55, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h0C, BYTE_LF
      };
      foreach (stream[i]) send_rx_byte(stream[i]);
   endtask

   // lengths over the cap, a zero cap, and a write to a register that is not there
   task automatic test_length_cap();
      // cap of two: the third body byte is read as checksum, the tail is hunted over
      logic [7:0] over_cap [0:10] = '{
         SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h05, 8'h11, 8'h22, 8'h33,
         BYTE_CR, BYTE_LF, 8'h44, 8'h55
      };
      // cap of zero with a full-scale length and a wrong second sync on its own
      logic [7:0] zero_cap [0:6] = '{
         SYNC_FIRST, 8'hA2, 8'hFF, 8'hFF, 8'h00, BYTE_CR, BYTE_LF
      };
      set_max_payload(16'd2);
      foreach (over_cap[i]) send_rx_byte(over_cap[i]);
      set_max_payload(16'd0);
      foreach (zero_cap[i]) send_rx_byte(zero_cap[i]);
      wait_block_idle();
      write_csr(UNUSED_ADDR, $urandom);
      check_max_payload_read();
   endtask

   // a mostly well-formed frame with random content, sometimes noisy or broken
   task automatic send_random_frame();
      logic [7:0]  frame_bytes [$];
      logic [15:0] len_field;
      logic [7:0]  sum;
      logic [7:0]  data;
      int unsigned body;
      int unsigned fault;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            data = 8'($urandom);
            // a stray sync with a wide cap would swallow many frames
            if (data == SYNC_FIRST && cap_value > 20) data = ~SYNC_FIRST;
            send_rx_byte(data);
         end
      end
      if (cap_value <= 20)
         len_field = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, cap_value + 3));
      else
         len_field = 16'($urandom_range(0, 12));
      body = (len_field > int'(cap_value) + 4) ? int'(cap_value) + 4 : len_field;
      sum  = '0;
      frame_bytes.push_back(SYNC_FIRST);
      frame_bytes.push_back(SYNC_SECOND);
      frame_bytes.push_back(len_field[15:8]);
      frame_bytes.push_back(len_field[7:0]);
      repeat (body) begin
         data = 8'($urandom);
         sum  = sum ^ data;
         frame_bytes.push_back(data);
      end
      frame_bytes.push_back(sum);
      frame_bytes.push_back(BYTE_CR);
      frame_bytes.push_back(BYTE_LF);
      fault = $urandom_range(0, 11);
      case (fault)
         0: frame_bytes[1] = frame_bytes[1] ^ 8'($urandom_range(1, 255));
         1: frame_bytes[frame_bytes.size() - 3] =
               frame_bytes[frame_bytes.size() - 3] ^ 8'($urandom_range(1, 255));
         2: frame_bytes[frame_bytes.size() - 2] =
               frame_bytes[frame_bytes.size() - 2] ^ 8'($urandom_range(1, 255));
         3: frame_bytes[frame_bytes.size() - 1] =
               frame_bytes[frame_bytes.size() - 1] ^ 8'($urandom_range(1, 255));
         4: begin
            // cut short, only where the next frame cannot open a long one
            if (cap_value <= 20)
               repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
         end
         default: ;
      endcase
      foreach (frame_bytes[i]) send_rx_byte(frame_bytes[i]);
   endtask

   // phases of random frames, each under its own cap and idling mix
   task automatic test_random_frames();
      logic [15:0] cap;
      int unsigned first;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 5)
            0: cap = 16'd0;
            1: cap = 16'd1;
            2: cap = 16'($urandom_range(2, 20));
            3: cap = 16'hFFFF;
            default: cap = 16'($urandom_range(21, 1000));
         endcase
         set_max_payload(cap);
         tx_idle_on = ($urandom_range(0, 2) != 0);
         rx_idle_on = ($urandom_range(0, 2) != 0);
         first = parsed_items;
         while (parsed_items - first < ITEMS_PER_PHASE) send_random_frame();
      end
   endtask

   // receiver holds off while the sender streams a long frame back to back
   task automatic test_receiver_hold_off();
      logic [7:0] sum;
      logic [7:0] data;
      set_max_payload(MAX_PAYLOAD_RESET);
      tx_idle_on       = 1'b0;
      rx_idle_on       = 1'b0;
      hold_off_request = 1'b1;
      sum = '0;
      send_rx_byte(SYNC_FIRST);
      send_rx_byte(SYNC_SECOND);
      send_rx_byte(8'h00);
      send_rx_byte(8'd48);
      repeat (48) begin
         data = 8'($urandom);
         sum  = sum ^ data;
         send_rx_byte(data);
      end
      send_rx_byte(sum);
      send_rx_byte(BYTE_CR);
      send_rx_byte(BYTE_LF);
   endtask

   // stimulus sequence and end of run
   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_register();
      test_directed_frames();
      test_length_cap();
      test_random_frames();
      test_receiver_hold_off();
      wait_block_idle();
      if (error_count == 0)
         $display("xor_checked_frame_parser_tb: clean");
      else
         $display("xor_checked_frame_parser_tb: errors");
      $finish;
   end

   // result receiver: random stall per result, plus one long hold-off on request
   initial begin : result_receiver
      int unsigned wait_n;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end
         wait_n = rx_idle_on ? $urandom_range(0, 9) : 0;
         if (wait_n != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // compare each accepted result with the oldest expected one
   always @(posedge clock) begin : result_checker
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_error($sformatf("unexpected result kind %0d byte %02h status %0d length %0d",
                                   rsp_kind, rsp_payload_byte, rsp_frame_status,
                                   rsp_frame_length));
         end else begin
            want = expected_results.pop_front();
            if (rsp_kind !== want.kind || rsp_payload_byte !== want.payload_byte ||
                rsp_frame_status !== want.frame_status ||
                rsp_frame_length !== want.frame_length)
               report_error($sformatf(
                  "expected kind %0d byte %02h status %0d length %0d, got %0d %02h %0d %0d",
                  want.kind, want.payload_byte, want.frame_status, want.frame_length,
                  rsp_kind, rsp_payload_byte, rsp_frame_status, rsp_frame_length));
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("xor_checked_frame_parser_tb: errors");
         $finish;
      end
   end

endmodule
